[hw/rtl/gps_pkg.sv]
// Shared constants, register indexes and the command type of the granular pitch shifter.
package gps_pkg;

    localparam int DEPTH = 4096;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = (AW > 12) ? AW : 12;
    localparam int NCH   = 2;
    localparam int WW    = 22;
    localparam int CIW   = 3;

    localparam logic [CIW-1:0] CFG_PLAY_SPEED = 3'd0;
    localparam logic [CIW-1:0] CFG_SHIFT_ACT  = 3'd1;
    localparam logic [CIW-1:0] CFG_CHUNK      = 3'd2;
    localparam logic [CIW-1:0] CFG_OVERLAP    = 3'd3;
    localparam logic [CIW-1:0] CFG_WET_MIX    = 3'd4;

    localparam logic [15:0] RST_SPEED = 16'd4096;
    localparam logic [11:0] RST_CHUNK = 12'd1024;
    localparam logic [10:0] RST_OV    = 11'd256;
    localparam logic [15:0] MIX_FULL  = 16'h8000;

    typedef struct packed {
        logic [15:0]             dry_l;
        logic [15:0]             dry_r;
        logic                    wr_en;
        logic [AW-1:0]           wr_addr;
        logic                    wet;
        logic [2:0][AW-1:0]      addr;
        logic [2:0]              vld;
        logic [2:0][WW-1:0]      wgt;
        logic [WW-1:0]           den;
        logic [15:0]             mix;
    } t_cmd;

endpackage

[hw/rtl/gps_fifo.sv]
// Two-entry command queue between the front end and the back end.
module gps_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gps_pkg::t_cmd i_data,
    input  logic          i_pop,
    output gps_pkg::t_cmd o_data,
    output logic          o_full,
    output logic          o_empty
);
    import gps_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("Queue count out of range.");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_count == 2'd2)) else $error("Push into a full queue.");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_count == 2'd0)) else $error("Pop from an empty queue.");

endmodule

[hw/rtl/gps_front.sv]
// Front end: configuration, grain bookkeeping and per-frame command generation.
module gps_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic [gps_pkg::CIW-1:0]  i_cfg_index,
    input  logic [15:0]              i_cfg_data,
    output logic                     o_cfg_ready,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [15:0]              i_sl,
    input  logic [15:0]              i_sr,
    input  logic                     i_byp,
    output logic                     o_push,
    output gps_pkg::t_cmd            o_cmd,
    input  logic                     i_full
);
    import gps_pkg::*;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_MUL  = 3'd1;
    localparam logic [2:0] F_DIV  = 3'd2;
    localparam logic [2:0] F_WGT  = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;

    localparam logic [1:0] GR_PLAIN = 2'd0;
    localparam logic [1:0] GR_PREV  = 2'd1;
    localparam logic [1:0] GR_TRI   = 2'd2;
    localparam logic [1:0] GR_OLAP  = 2'd3;

    localparam logic [AW-1:0] GS_RST = AW'(PW'(0) - PW'(RST_CHUNK));
    localparam logic [AW-1:0] PV_RST = AW'(PW'(0) - PW'(RST_CHUNK) - PW'(RST_OV));

    logic [2:0]          r_state;
    logic [15:0]         r_ps;
    logic                r_act;
    logic [11:0]         r_chunk;
    logic [10:0]         r_ov;
    logic [15:0]         r_mix;
    logic [AW-1:0]       r_wc;
    logic                r_full;
    logic [11:0]         r_gc;
    logic [AW-1:0]       r_gs;
    logic [AW-1:0]       r_pvs;
    logic [AW-1:0]       r_pps;
    logic [11:0]         r_tbs;
    logic                r_tbv;
    logic [15:0]         r_dl;
    logic [15:0]         r_dr;
    logic                r_pass;
    logic [27:0]         r_prod;
    logic [15:0]         r_rem;
    logic [3:0]          r_cnt;
    logic [3:0][WW-1:0]  r_p;
    logic [1:0]          r_k;

    logic                degen;
    logic [11:0]         len;
    logic [27:0]         prod_c;
    logic [27:0]         dsh;
    logic [15:0]         scaled;
    logic [11:0]         step;
    logic [11:0]         ov12;
    logic [11:0]         r2;
    logic [11:0]         dv;
    logic [11:0]         omr2;
    logic [11:0]         ma;
    logic [11:0]         mb;
    logic [23:0]         wm;
    logic [15:0]         mixs;
    logic                wet;
    logic                step_le_ov;
    logic [1:0]          gcase;
    logic [AW-1:0]       a_cur;
    logic [AW-1:0]       a_pv;
    logic [AW-1:0]       a_pp;
    logic [AW-1:0]       a_ol;
    logic [11:0]         gc1;
    logic                accept;
    logic                cfg_we;

    assign o_cfg_ready = (r_state == F_IDLE);
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign o_in_ready  = (r_state == F_IDLE) && !i_cfg_valid;
    assign accept      = i_in_valid && o_in_ready;
    assign o_push      = (r_state == F_PUSH) && !i_full;

    always_comb begin
        ov12       = {1'b0, r_ov};
        degen      = (r_chunk < 12'd2) || (r_ov == 11'd0) || (r_chunk <= ov12);
        len        = r_chunk - ov12;
        prod_c     = 28'(r_gc) * 28'(r_ps);
        dsh        = 28'(len) << r_cnt;
        scaled     = r_prod[27:12];
        step       = r_rem[11:0];
        r2         = (r_tbs < ov12) ? r_tbs : ov12;
        dv         = ov12 - step;
        omr2       = ov12 - r2;
        ma         = ov12;
        mb         = ov12;
        case (r_k)
            2'd1: begin
                ma = step;
            end
            2'd2: begin
                ma = r2;
                mb = dv;
            end
            2'd3: begin
                ma = omr2;
                mb = dv;
            end
            default: begin
                ma = ov12;
            end
        endcase
        wm         = 24'(ma) * 24'(mb);
        mixs       = (r_mix > MIX_FULL) ? MIX_FULL : r_mix;
        wet        = r_act && (mixs != 16'd0);
        step_le_ov = (step <= ov12);
        if (scaled <= 16'(r_ov)) begin
            gcase = r_tbv ? GR_TRI : GR_PREV;
        end else if (step_le_ov) begin
            gcase = GR_OLAP;
        end else begin
            gcase = GR_PLAIN;
        end
        a_cur = AW'(PW'(r_gs) - PW'(r_chunk) + PW'(step));
        a_pv  = AW'(PW'(r_pvs) + PW'(step));
        a_pp  = AW'(PW'(r_pps) + PW'(step));
        a_ol  = AW'(PW'(r_gs) - PW'(r_ov) + PW'(step));
        gc1   = r_gc + 12'd1;

        o_cmd.dry_l   = r_dl;
        o_cmd.dry_r   = r_dr;
        o_cmd.wr_en   = !r_pass;
        o_cmd.wr_addr = r_wc;
        o_cmd.wet     = !r_pass && wet;
        o_cmd.addr[0] = a_cur;
        o_cmd.addr[1] = (gcase == GR_OLAP) ? a_ol : a_pv;
        o_cmd.addr[2] = a_pp;
        for (int i = 0; i < 3; i++) begin
            o_cmd.vld[i] = r_full || (o_cmd.addr[i] <= r_wc);
        end
        o_cmd.mix = mixs;
        unique case (gcase)
            GR_TRI: begin
                o_cmd.wgt[0] = r_p[1];
                o_cmd.wgt[1] = r_p[2];
                o_cmd.wgt[2] = r_p[3];
                o_cmd.den    = r_p[0];
            end
            GR_PREV, GR_OLAP: begin
                o_cmd.wgt[0] = WW'(step);
                o_cmd.wgt[1] = WW'(dv);
                o_cmd.wgt[2] = '0;
                o_cmd.den    = WW'(r_ov);
            end
            default: begin
                o_cmd.wgt[0] = WW'(1);
                o_cmd.wgt[1] = '0;
                o_cmd.wgt[2] = '0;
                o_cmd.den    = WW'(1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_ps    <= RST_SPEED;
            r_act   <= 1'b0;
            r_chunk <= RST_CHUNK;
            r_ov    <= RST_OV;
            r_mix   <= MIX_FULL;
            r_wc    <= '0;
            r_full  <= 1'b0;
            r_gc    <= '0;
            r_gs    <= GS_RST;
            r_pvs   <= PV_RST;
            r_pps   <= PV_RST;
            r_tbs   <= '0;
            r_tbv   <= 1'b0;
            r_k     <= '0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_dl    <= i_sl;
                        r_dr    <= (NCH == 2) ? i_sr : 16'd0;
                        r_pass  <= i_byp || degen;
                        r_state <= (i_byp || degen) ? F_PUSH : F_MUL;
                    end
                end
                F_MUL: begin
                    r_prod  <= prod_c;
                    r_rem   <= prod_c[27:12];
                    r_cnt   <= 4'd15;
                    r_state <= F_DIV;
                end
                F_DIV: begin
                    if ({12'd0, r_rem} >= dsh) begin
                        r_rem <= r_rem - dsh[15:0];
                    end
                    if (r_cnt == 4'd0) begin
                        r_k     <= 2'd0;
                        r_state <= F_WGT;
                    end else begin
                        r_cnt <= r_cnt - 4'd1;
                    end
                end
                F_WGT: begin
                    r_p[r_k] <= wm[WW-1:0];
                    r_k      <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                        if (!r_pass) begin
                            if (wet && gcase == GR_TRI && r_tbs != 12'hFFF
                                    && !(gc1 > len && step_le_ov)) begin
                                r_tbs <= r_tbs + 12'd1;
                            end
                            if (gc1 > len) begin
                                r_pvs <= a_cur;
                                if (step_le_ov) begin
                                    r_pps <= a_ol;
                                    r_tbs <= step + 12'd1;
                                    r_tbv <= 1'b1;
                                end else begin
                                    r_pps <= a_cur;
                                    r_tbv <= 1'b0;
                                end
                                r_gc <= '0;
                                r_gs <= r_wc;
                            end else begin
                                r_gc <= gc1;
                            end
                            r_wc <= r_wc + AW'(1);
                            if (r_wc == AW'(DEPTH - 1)) begin
                                r_full <= 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
            if (cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PLAY_SPEED: begin
                        r_ps <= i_cfg_data;
                    end
                    CFG_SHIFT_ACT: begin
                        r_act <= i_cfg_data[0];
                    end
                    CFG_CHUNK: begin
                        if (i_cfg_data[11:0] != r_chunk) begin
                            r_chunk <= i_cfg_data[11:0];
                            r_gc    <= '0;
                            r_gs    <= AW'(PW'(0) - PW'(i_cfg_data[11:0]));
                            r_pvs   <= AW'(PW'(0) - PW'(i_cfg_data[11:0]) - PW'(r_ov));
                            r_pps   <= AW'(PW'(0) - PW'(i_cfg_data[11:0]) - PW'(r_ov));
                            r_tbv   <= 1'b0;
                        end
                    end
                    CFG_OVERLAP: begin
                        if (i_cfg_data[10:0] != r_ov) begin
                            r_ov  <= i_cfg_data[10:0];
                            r_gc  <= '0;
                            r_gs  <= AW'(PW'(0) - PW'(r_chunk));
                            r_pvs <= AW'(PW'(0) - PW'(r_chunk) - PW'(i_cfg_data[10:0]));
                            r_pps <= AW'(PW'(0) - PW'(r_chunk) - PW'(i_cfg_data[10:0]));
                            r_tbv <= 1'b0;
                        end
                    end
                    CFG_WET_MIX: begin
                        r_mix <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

[hw/rtl/gps_back.sv]
// Back end: delay-line memories, grain crossfade, wet/dry mix and the output register.
module gps_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    output logic          o_pop,
    input  gps_pkg::t_cmd i_cmd,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [15:0]   o_out_l,
    output logic [15:0]   o_out_r
);
    import gps_pkg::*;

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_WR   = 4'd1;
    localparam logic [3:0] B_RD   = 4'd2;
    localparam logic [3:0] B_MAC  = 4'd3;
    localparam logic [3:0] B_P1   = 4'd4;
    localparam logic [3:0] B_P2   = 4'd5;
    localparam logic [3:0] B_P3   = 4'd6;
    localparam logic [3:0] B_SUM  = 4'd7;
    localparam logic [3:0] B_DIV  = 4'd8;
    localparam logic [3:0] B_FIN  = 4'd9;
    localparam logic [3:0] B_OUT  = 4'd10;

    logic [15:0]          mem_l [DEPTH];
    logic [15:0]          mem_r [DEPTH];
    logic [15:0]          r_rd_l;
    logic [15:0]          r_rd_r;

    t_cmd                 r_cmd;
    logic [3:0]           r_state;
    logic [1:0]           r_k;
    logic                 r_ch;
    logic [1:0][2:0][15:0] r_smp;
    logic signed [39:0]   r_acc;
    logic signed [55:0]   r_p1;
    logic signed [38:0]   r_p2;
    logic signed [55:0]   r_p3;
    logic [39:0]          r_rem;
    logic [15:0]          r_q;
    logic [3:0]           r_cnt;
    logic [15:0]          r_res_l;
    logic [15:0]          r_res_r;
    logic                 r_ovld;
    logic [15:0]          r_out_l;
    logic [15:0]          r_out_r;

    logic [1:0]           k_idx;
    logic [1:0]           k_cap;
    logic [AW-1:0]        rd_addr;
    logic signed [15:0]   s_cur;
    logic signed [22:0]   w_cur;
    logic signed [38:0]   mac_p;
    logic signed [16:0]   mix_s;
    logic signed [16:0]   imix_s;
    logic signed [22:0]   den_s;
    logic signed [15:0]   dry_s;
    logic signed [57:0]   x_sum;
    logic [39:0]          dsh;
    logic                 q_bit;
    logic                 out_load;

    assign o_pop       = (r_state == B_IDLE) && !i_empty;
    assign o_out_valid = r_ovld;
    assign o_out_l     = r_out_l;
    assign o_out_r     = r_out_r;
    assign out_load    = (r_state == B_OUT) && (!r_ovld || i_out_ready);

    always_comb begin
        k_idx   = (r_k == 2'd3) ? 2'd2 : r_k;
        k_cap   = r_k - 2'd1;
        rd_addr = r_cmd.addr[k_idx];
        s_cur   = $signed(r_smp[r_ch][k_idx]);
        w_cur   = $signed({1'b0, r_cmd.wgt[k_idx]});
        mac_p   = s_cur * w_cur;
        mix_s   = $signed({1'b0, r_cmd.mix});
        imix_s  = $signed({1'b0, MIX_FULL - r_cmd.mix});
        den_s   = $signed({1'b0, r_cmd.den});
        dry_s   = $signed(r_ch ? r_cmd.dry_r : r_cmd.dry_l);
        x_sum   = (58'(r_p1) + 58'(r_p3)) * 58'sd2
                + $signed({21'd0, r_cmd.den, 15'd0})
                + $signed({5'd0, r_cmd.den, 31'd0});
        dsh     = 40'(r_cmd.den) << r_cnt;
        q_bit   = (r_rem >= dsh);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_WR && r_cmd.wr_en) begin
            mem_l[r_cmd.wr_addr] <= r_cmd.dry_l;
            mem_r[r_cmd.wr_addr] <= r_cmd.dry_r;
        end
        r_rd_l <= mem_l[rd_addr];
        r_rd_r <= mem_r[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ovld  <= 1'b0;
            r_k     <= '0;
            r_ch    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (out_load) begin
                r_ovld  <= 1'b1;
                r_out_l <= r_res_l;
                r_out_r <= r_res_r;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_cmd   <= i_cmd;
                        r_state <= B_WR;
                    end
                end
                B_WR: begin
                    r_res_l <= r_cmd.dry_l;
                    r_res_r <= (NCH == 2) ? r_cmd.dry_r : 16'd0;
                    r_k     <= 2'd0;
                    r_state <= r_cmd.wet ? B_RD : B_OUT;
                end
                B_RD: begin
                    if (r_k != 2'd0) begin
                        r_smp[0][k_cap] <= r_cmd.vld[k_cap] ? r_rd_l : 16'd0;
                        r_smp[1][k_cap] <= r_cmd.vld[k_cap] ? r_rd_r : 16'd0;
                    end
                    if (r_k == 2'd3) begin
                        r_k     <= 2'd0;
                        r_ch    <= 1'b0;
                        r_acc   <= '0;
                        r_state <= B_MAC;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                B_MAC: begin
                    r_acc <= r_acc + 40'(mac_p);
                    r_k   <= r_k + 2'd1;
                    if (r_k == 2'd2) begin
                        r_state <= B_P1;
                    end
                end
                B_P1: begin
                    r_p1    <= r_acc * mix_s;
                    r_state <= B_P2;
                end
                B_P2: begin
                    r_p2    <= dry_s * den_s;
                    r_state <= B_P3;
                end
                B_P3: begin
                    r_p3    <= r_p2 * imix_s;
                    r_state <= B_SUM;
                end
                B_SUM: begin
                    r_rem   <= x_sum[55:16];
                    r_cnt   <= 4'd15;
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    if (q_bit) begin
                        r_rem <= r_rem - dsh;
                    end
                    r_q <= {r_q[14:0], q_bit};
                    if (r_cnt == 4'd0) begin
                        r_state <= B_FIN;
                    end else begin
                        r_cnt <= r_cnt - 4'd1;
                    end
                end
                B_FIN: begin
                    if (r_ch) begin
                        r_res_r <= r_q ^ MIX_FULL;
                    end else begin
                        r_res_l <= r_q ^ MIX_FULL;
                    end
                    if (!r_ch && NCH == 2) begin
                        r_ch    <= 1'b1;
                        r_k     <= 2'd0;
                        r_acc   <= '0;
                        r_state <= B_MAC;
                    end else begin
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (out_load) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

[hw/rtl/granular_pitch_shifter.sv]
// Top level of the granular pitch shifter: stream ports, configuration port and the two halves.
// One stereo frame is taken per input transfer and gives one output transfer. The front end
// works through a frame with one multiply, a 16-step serial modulo of the scaled grain count
// and four passes through a shared weight multiplier; the back end works through a shifted
// frame with a 16-step serial divider that runs once per channel, and passes a bypassed or dry
// frame through without it. A two-entry command queue lets the halves overlap, so the front end
// can take a new frame while the back end is still busy with earlier ones. Configuration writes
// are taken only while the front end is idle, and an input transfer waits while a write is
// offered. The delay lines need no clearing pass: a fill count marks entries not yet written
// since reset, and those read as zero.
module granular_pitch_shifter (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [gps_pkg::CIW-1:0]  i_cfg_index,
    input  logic [15:0]              i_cfg_data,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [31:0]              s_axis_tdata,  // sample_left, sample_right
    input  logic                     s_axis_tuser,  // bypass
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [31:0]              m_axis_tdata   // out_left, out_right
);
    import gps_pkg::*;

    t_cmd fr_cmd;
    t_cmd q_cmd;
    logic fr_push;
    logic q_full;
    logic q_empty;
    logic bk_pop;

    gps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_sl        (s_axis_tdata[15:0]),
        .i_sr        (s_axis_tdata[31:16]),
        .i_byp       (s_axis_tuser),
        .o_push      (fr_push),
        .o_cmd       (fr_cmd),
        .i_full      (q_full)
    );

    gps_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_data  (fr_cmd),
        .i_pop   (bk_pop),
        .o_data  (q_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    gps_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .o_pop       (bk_pop),
        .i_cmd       (q_cmd),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_l     (m_axis_tdata[15:0]),
        .o_out_r     (m_axis_tdata[31:16])
    );

endmodule

[tb/granular_pitch_shifter_tb.sv]
// Self-checking testbench for the granular pitch shifter: directed table, then randomized phases.
`timescale 1ns / 100ps

module granular_pitch_shifter_tb;
    import gps_pkg::*;

    typedef struct {
        bit               is_cfg;
        logic [CIW-1:0]   idx;
        logic [15:0]      val;
        logic [15:0]      left;
        logic [15:0]      right;
        bit               byp;
        bit               typed;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CIW-1:0]   i_cfg_index = '0;
    logic [15:0]      i_cfg_data = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [31:0]      s_axis_tdata = '0;
    logic             s_axis_tuser = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [31:0]      m_axis_tdata;

    int               snd_idle = 0;
    int               rcv_stall = 0;
    int               err_count = 0;
    int               frames_sent = 0;
    int               frames_seen = 0;
    int               cfg_writes = 0;
    logic [31:0]      frame_q[$];
    t_row             rows[$];

    int               spd, shift_on, chunk, ovl, wmix;
    int               wcur, gcnt, gstart, pstart, ppstart, blend_step;
    bit               blend_valid;
    logic signed [15:0] line_l [DEPTH];
    logic signed [15:0] line_r [DEPTH];

    granular_pitch_shifter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic int wrap_pos(longint v);
        longint r;
        r = v % DEPTH;
        if (r < 0) r += DEPTH;
        return int'(r);
    endfunction

    function automatic logic [15:0] round_sat16(longint num, longint den);
        longint n2, d2, q;
        n2 = 2 * num + den;
        d2 = 2 * den;
        if (n2 >= 0) q = n2 / d2;
        else q = -((-n2 + d2 - 1) / d2);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic longint tap(int ch, int idx);
        return ch ? longint'(line_r[idx]) : longint'(line_l[idx]);
    endfunction

    function automatic void restart_grains();
        gcnt = 0;
        gstart = wrap_pos(DEPTH - chunk);
        pstart = wrap_pos(DEPTH - chunk - ovl);
        ppstart = pstart;
        blend_valid = 1'b0;
    endfunction

    function automatic void shifter_reset();
        spd = 4096; shift_on = 0; chunk = 1024; ovl = 256; wmix = 32768;
        for (int i = 0; i < DEPTH; i++) begin
            line_l[i] = '0;
            line_r[i] = '0;
        end
        wcur = 0;
        blend_step = 0;
        restart_grains();
    endfunction

    function automatic void apply_reg(logic [CIW-1:0] idx, logic [15:0] val);
        case (idx)
            CFG_PLAY_SPEED: spd = val;
            CFG_SHIFT_ACT:  shift_on = val[0];
            CFG_CHUNK: begin
                if (val[11:0] != chunk) begin
                    chunk = val[11:0];
                    restart_grains();
                end
            end
            CFG_OVERLAP: begin
                if (val[10:0] != ovl) begin
                    ovl = val[10:0];
                    restart_grains();
                end
            end
            CFG_WET_MIX: wmix = val;
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] shift_frame(logic [15:0] left, logic [15:0] right, bit byp);
        longint dry[2], num, den, cur, pv, pp, r2, inner, ov, step;
        int len, scaled, mix, s2, st;
        bit wet_on, used3;
        logic [15:0] res[2];
        dry[0] = longint'($signed(left));
        dry[1] = longint'($signed(right));
        res[0] = left;
        res[1] = right;
        used3 = 1'b0;
        ov = ovl;
        if (byp || chunk < 2 || ovl == 0 || chunk <= ovl) return {right, left};
        len = chunk - ovl;
        mix = (wmix > 32768) ? 32768 : wmix;
        wet_on = (shift_on != 0) && (mix != 0);
        scaled = int'((longint'(gcnt) * spd) >>> 12);
        step = scaled % len;
        line_l[wcur] = left;
        line_r[wcur] = right;
        if (wet_on) begin
            for (int ch = 0; ch < 2; ch++) begin
                cur = tap(ch, wrap_pos(gstart - chunk + step));
                if (scaled <= ov) begin
                    pv = tap(ch, wrap_pos(pstart + step));
                    if (!blend_valid) begin
                        num = cur * step + pv * (ov - step);
                        den = ov;
                    end else begin
                        pp = tap(ch, wrap_pos(ppstart + step));
                        r2 = (blend_step < ov) ? blend_step : ov;
                        inner = pv * r2 + pp * (ov - r2);
                        num = cur * step * ov + inner * (ov - step);
                        den = ov * ov;
                        used3 = 1'b1;
                    end
                end else if (step <= ov) begin
                    pv = tap(ch, wrap_pos(gstart - ov + step));
                    num = cur * step + pv * (ov - step);
                    den = ov;
                end else begin
                    num = cur;
                    den = 1;
                end
                res[ch] = round_sat16(num * mix + dry[ch] * den * (32768 - mix), den * 32768);
            end
        end
        if (used3 && blend_step < 4095) blend_step++;
        gcnt++;
        if (gcnt > len) begin
            s2 = int'((longint'(gcnt - 1) * spd) >>> 12);
            st = s2 % len;
            if (st <= ovl) begin
                ppstart = wrap_pos(gstart - ovl + st);
                pstart = wrap_pos(gstart - chunk + st);
                blend_step = st + 1;
                blend_valid = 1'b1;
            end else begin
                pstart = wrap_pos(gstart - chunk + st);
                ppstart = pstart;
                blend_valid = 1'b0;
            end
            gcnt = 0;
            gstart = wcur;
        end
        wcur = (wcur + 1) % DEPTH;
        return {res[1], res[0]};
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic write_reg(logic [CIW-1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, val);
        cfg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_frame(logic [15:0] left, logic [15:0] right, bit byp, bit typed);
        logic [31:0] predicted;
        while ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {right, left};
        s_axis_tuser  <= byp;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = shift_frame(left, right, byp);
        frame_q.push_back(typed ? {right, left} : predicted);
        frames_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (frame_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_cfg(logic [CIW-1:0] idx, logic [15:0] val);
        rows.push_back('{1'b1, idx, val, 16'h0, 16'h0, 1'b0, 1'b0});
    endtask

    task automatic add_frame(logic [15:0] left, logic [15:0] right, bit byp, bit typed);
        rows.push_back('{1'b0, '0, 16'h0, left, right, byp, typed});
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rcv_stall);
    end

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            frames_seen++;
            if (frame_q.size() == 0) begin
                report_mismatch($sformatf("unexpected output %h", m_axis_tdata));
            end else begin
                want = frame_q.pop_front();
                if (m_axis_tdata[15:0] !== want[15:0])
                    report_mismatch($sformatf("out_left %h, want %h",
                                              m_axis_tdata[15:0], want[15:0]));
                if (m_axis_tdata[31:16] !== want[31:16])
                    report_mismatch($sformatf("out_right %h, want %h",
                                              m_axis_tdata[31:16], want[31:16]));
            end
        end
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int n_ch, n_ov;
        shifter_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_frame(16'h7FFF, 16'h8000, 1'b0, 1'b1);
        add_frame(16'h8000, 16'h7FFF, 1'b0, 1'b1);
        add_frame(16'h0000, 16'hFFFF, 1'b1, 1'b1);
        add_cfg(CFG_SHIFT_ACT, 16'h0001);
        add_cfg(CFG_CHUNK, 16'd8);
        add_cfg(CFG_OVERLAP, 16'd3);
        add_cfg(CFG_PLAY_SPEED, 16'd6144);
        for (int i = 0; i < 10; i++)
            add_frame(i[0] ? 16'h7FFF : 16'h8000, i[1] ? 16'h8000 : 16'h7FFF, 1'b0, 1'b0);
        add_cfg(CFG_WET_MIX, 16'hFFFF);
        add_frame(16'h7FFF, 16'h8001, 1'b0, 1'b0);
        add_frame(16'h1234, 16'hFEDC, 1'b0, 1'b0);
        add_cfg(CFG_WET_MIX, 16'h0000);
        add_frame(16'h4321, 16'hABCD, 1'b0, 1'b1);
        add_cfg(CFG_WET_MIX, 16'h4000);
        add_frame(16'h5555, 16'hAAAA, 1'b1, 1'b1);
        add_cfg(CFG_CHUNK, 16'd1);
        add_frame(16'h0101, 16'h0202, 1'b0, 1'b1);
        add_cfg(CFG_CHUNK, 16'd8);
        add_cfg(CFG_OVERLAP, 16'd0);
        add_frame(16'h0303, 16'h0404, 1'b0, 1'b1);
        add_cfg(CFG_OVERLAP, 16'd8);
        add_frame(16'h0505, 16'h0606, 1'b0, 1'b1);
        add_cfg(3'd5, 16'hFFFF);
        add_cfg(3'd6, 16'h0000);
        add_cfg(3'd7, 16'h1234);
        add_cfg(CFG_OVERLAP, 16'd3);
        add_frame(16'h7FFF, 16'h7FFF, 1'b0, 1'b0);
        add_frame(16'h8000, 16'h8000, 1'b0, 1'b0);

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                drain();
                write_reg(rows[i].idx, rows[i].val);
            end else begin
                send_frame(rows[i].left, rows[i].right, rows[i].byp, rows[i].typed);
            end
        end

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            case (ph % 4)
                0: begin snd_idle = 0;  rcv_stall = 0;  end
                1: begin snd_idle = 88; rcv_stall = 0;  end
                2: begin snd_idle = 0;  rcv_stall = 88; end
                default: begin snd_idle = 14; rcv_stall = 14; end
            endcase
            n_ch = $urandom_range(64, 6);
            n_ov = $urandom_range(n_ch / 2, 1);
            if (ph == 7) begin
                n_ch = 4095;
                n_ov = 2047;
            end
            write_reg(CFG_CHUNK, 16'(n_ch));
            write_reg(CFG_OVERLAP, 16'(n_ov));
            write_reg(CFG_SHIFT_ACT, 16'(ph != 5));
            case (ph)
                0: write_reg(CFG_PLAY_SPEED, 16'hFFFF);
                1: write_reg(CFG_PLAY_SPEED, 16'h0000);
                default: write_reg(CFG_PLAY_SPEED, 16'($urandom_range(16384, 1024)));
            endcase
            case (ph)
                0, 7: write_reg(CFG_WET_MIX, MIX_FULL);
                1: write_reg(CFG_WET_MIX, 16'd1);
                default: write_reg(CFG_WET_MIX, 16'($urandom_range(32768)));
            endcase
            for (int k = 0; k < 80; k++) begin
                if (k == 40) drain();
                send_frame(rand_sample(), rand_sample(), ($urandom_range(15) == 0), 1'b0);
            end
        end

        drain();
        $display("Covered %0d frames and %0d register writes over eight idle/stall phases,",
                 frames_sent, cfg_writes);
        $display("including bypass, dry, degenerate grain and wide-grain settings.");
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[granular_pitch_shifter.f]
hw/rtl/gps_pkg.sv
hw/rtl/gps_fifo.sv
hw/rtl/gps_front.sv
hw/rtl/gps_back.sv
hw/rtl/granular_pitch_shifter.sv
tb/granular_pitch_shifter_tb.sv
